// ===== hdl/kxb32_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kxb32_pkg;

	// Key store: four 64-bit words, 32 bytes in all
	localparam int KEY_WORDS     = 4;
	localparam int KEY_TOTAL     = 32;
	localparam int KEY_IDX_W     = 5;
	localparam int KEY_BYTES_DEF = 32;
	localparam int CFG_IDX_W     = 8;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef logic [4:0] sym_idx_t;

	// One classified byte: up to three symbol indices ready for emission
	typedef struct packed {
		logic [1:0]          n;
		sym_idx_t [2:0]      sym;
		logic                last;
	} grp_t;

	// RFC 4648 base32 alphabet: A..Z then 2..7
	function automatic logic [6:0] b32_char(input sym_idx_t idx);
		logic [6:0] c;
		if (idx < 5'd26) begin
			c = 7'h41 + {2'b00, idx};
		end else begin
			c = 7'h32 + {2'b00, idx - 5'd26};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kxb32_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kxb32_front import kxb32_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [KEY_TOTAL-1:0][7:0]     key_b,
	input  wire logic                          in_push,
	input  wire logic [7:0]                    in_data,
	input  wire logic                          in_last,
	output grp_t                               grp
);

	localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic [7:0]    pos_q;
	logic [KW-1:0] kidx_q;
	logic [3:0]    acc_q;
	logic [2:0]    cnt_q;

	logic [KEY_IDX_W-1:0] kidx5;
	logic [7:0]           x;
	logic [11:0]          wide;
	logic [3:0]           tot;
	logic [3:0]           sh0;
	logic [3:0]           sh1;
	logic                 two;
	logic [2:0]           rem;
	logic                 flush;
	sym_idx_t             sym0;
	sym_idx_t             sym1;
	sym_idx_t             fsym;
	logic [3:0]           acc_mask;

	always_comb begin
		kidx5    = KEY_IDX_W'(kidx_q);
		x        = in_data ^ key_b[kidx5] ^ pos_q;
		wide     = {acc_q, x};
		tot      = {1'b0, cnt_q} + 4'd8;
		sh0      = tot - 4'd5;
		sh1      = tot - 4'd10;
		two      = (tot >= 4'd10);
		rem      = two ? 3'(sh1) : 3'(sh0);
		flush    = in_last && (rem != 3'd0);
		sym0     = 5'(wide >> sh0);
		sym1     = 5'(wide >> sh1);
		// left-align leftover bits, zero fill
		fsym     = 5'(wide << (3'd5 - rem));
		acc_mask = (4'd1 << rem) - 4'd1;

		grp.n      = 2'd1 + {1'b0, two} + {1'b0, flush};
		grp.sym[0] = sym0;
		grp.sym[1] = two ? sym1 : fsym;
		grp.sym[2] = fsym;
		grp.last   = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			kidx_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (in_push) begin
			if (in_last) begin
				pos_q  <= '0;
				kidx_q <= '0;
				acc_q  <= '0;
				cnt_q  <= '0;
			end else begin
				pos_q <= pos_q + 8'd1;
				// key index follows position mod KEY_BYTES, including the wrap at 256
				if (pos_q == 8'hFF || kidx_q == KW'(KEY_BYTES - 1)) begin
					kidx_q <= '0;
				end else begin
					kidx_q <= kidx_q + KW'(1);
				end
				acc_q <= wide[3:0] & acc_mask;
				cnt_q <= rem;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kxb32_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kxb32_fifo import kxb32_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire grp_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output grp_t      rd_data,
	output logic      empty
);

	grp_t           mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kxb32_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kxb32_back import kxb32_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire grp_t       grp,
	input  wire logic       grp_empty,
	output logic            grp_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [6:0]      symbol_char,
	output logic            last_symbol
);

	logic       valid_q;
	logic [1:0] sub_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load        = !grp_empty && (!valid_q || pop);
	assign at_end      = (sub_q == grp.n - 2'd1);
	assign grp_pop     = load && at_end;
	assign empty       = !valid_q;
	assign symbol_char = char_q;
	assign last_symbol = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b32_char(grp.sym[sub_q]);
			last_q <= grp.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				sub_q <= at_end ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/keyed_xor_base32_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------
// input     | push / full               | data_byte[7:0], last_byte
// result    | empty / pop               | symbol_char[6:0], last_symbol
// config    | cfg_valid / cfg_ready     | cfg_index[7:0], cfg_data[63:0]
//
// The front takes one byte per cycle while the four-entry group queue has room.
// The back emits one character per cycle while pop is held and groups wait, so a
// byte yields one to three characters (about 1.6 on average, two at most in steady
// state without a flush). A group goes through the queue, then the output register.
// Reset clears position, accumulator, key words, queue and output valid flag.
// Either side may stall on its own; the queue absorbs the difference.

module keyed_xor_base32_encoder import kxb32_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [6:0]                symbol_char,
	output logic                      last_symbol,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	// Key words; byte 0 of each word sits in its low bits
	logic [KEY_WORDS-1:0][63:0] key_q;
	logic [KEY_TOTAL-1:0][7:0]  key_b;

	logic q_push;
	logic q_full;
	logic q_empty;
	logic q_pop;
	grp_t grp_in;
	grp_t grp_out;

	assign key_b     = key_q;
	assign cfg_ready = 1'b1;
	assign full      = q_full;
	// accept a byte only when its group has a slot waiting
	assign q_push    = push && !q_full;

	// Take key writes; drop any index past the last key word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < CFG_IDX_W'(KEY_WORDS)) begin
				key_q[cfg_index[1:0]] <= cfg_data;
			end
		end
	end

	// Front: whiten the byte, pack bits and classify into one group
	kxb32_front #(
		.KEY_BYTES(KEY_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_b   (key_b),
		.in_push (q_push),
		.in_data (data_byte),
		.in_last (last_byte),
		.grp     (grp_in)
	);

	// Hold groups until the back is ready for them
	kxb32_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (grp_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (grp_out),
		.empty   (q_empty)
	);

	// Back: advance through the group one character per transaction
	kxb32_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp         (grp_out),
		.grp_empty   (q_empty),
		.grp_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.symbol_char (symbol_char),
		.last_symbol (last_symbol)
	);

`ifndef SYNTHESIS
	// Back never drains a group from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("group popped from empty queue");

	// An idle output register picks up a waiting group on the next edge
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !q_empty) |=> !empty)
		else $error("output stayed empty while a group waited");

	// Retiring a group always leaves its final character on the ports
	a_retire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !empty)
		else $error("group retired without a character shown");
`endif

endmodule

`default_nettype wire

// ===== dv/b32_cipher_checker.sv =====
`timescale 1ns / 1ps

module b32_cipher_checker import kxb32_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [6:0]           symbol_char,
	input  logic                 last_symbol,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   failures,
	output int                   chars_pending
);

	typedef struct packed {
		logic [6:0] symbol;
		logic       last;
	} b32_char_t;

	localparam logic [255:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
	localparam int           MAX_PRINTED  = 40;

	b32_char_t   cipher_chars_due[$];
	b32_char_t   oldest_due;
	logic [63:0] key_words_copy [KEY_WORDS];
	logic [7:0]  frag_pos;
	logic [11:0] bit_acc;
	int unsigned bit_count;
	int          mismatch_count;

	function automatic logic [6:0] b32_ascii(input logic [4:0] group);
		logic [7:0] code;
		code = B32_ALPHABET[8 * (31 - group) +: 8];
		return code[6:0];
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED) begin
			$display("[%0t] MISMATCH %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Encrypt one byte and pack it; key index is position mod 32 (default KEY_BYTES)
	task automatic encrypt_and_pack(input logic [7:0] plain, input logic frag_end);
		b32_char_t   made [3];
		int          n;
		int unsigned sh;
		logic [63:0] word;
		logic [11:0] shifted;
		logic [7:0]  cipher;
		n = 0;
		word = key_words_copy[frag_pos[4:3]] >> (8 * frag_pos[2:0]);
		cipher = plain ^ word[7:0] ^ frag_pos;
		bit_acc = {bit_acc[3:0], cipher};
		bit_count += 8;
		while (bit_count >= 5) begin
			sh = bit_count - 5;
			shifted = bit_acc >> sh;
			made[n].symbol = b32_ascii(shifted[4:0]);
			made[n].last = 1'b0;
			n++;
			bit_count = sh;
			bit_acc = bit_acc & ((12'd1 << sh) - 12'd1);
		end
		if (frag_end) begin
			// flush leftover bits left-aligned, zero-filled
			if (bit_count > 0) begin
				shifted = bit_acc << (5 - bit_count);
				made[n].symbol = b32_ascii(shifted[4:0]);
				made[n].last = 1'b0;
				n++;
			end
			made[n - 1].last = 1'b1;
			frag_pos = 8'd0;
			bit_acc = 12'd0;
			bit_count = 0;
		end else begin
			frag_pos = frag_pos + 8'd1;
		end
		for (int i = 0; i < n; i++) begin
			cipher_chars_due.push_back(made[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_words_copy[i] = 64'd0;
			end
			frag_pos = 8'd0;
			bit_acc = 12'd0;
			bit_count = 0;
			mismatch_count = 0;
			cipher_chars_due.delete();
			failures <= 0;
			chars_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < KEY_WORDS) begin
				key_words_copy[cfg_index[1:0]] = cfg_data;
			end
			if (pop && !empty) begin
				if (cipher_chars_due.size() == 0) begin
					report_mismatch($sformatf("char %02h last %0b with nothing due",
						symbol_char, last_symbol));
				end else begin
					oldest_due = cipher_chars_due.pop_front();
					if (symbol_char !== oldest_due.symbol) begin
						report_mismatch($sformatf("symbol_char %02h, due %02h",
							symbol_char, oldest_due.symbol));
					end
					if (last_symbol !== oldest_due.last) begin
						report_mismatch($sformatf("last_symbol %0b, due %0b",
							last_symbol, oldest_due.last));
					end
				end
			end
			if (push && !full) begin
				encrypt_and_pack(data_byte, last_byte);
			end
			failures <= mismatch_count;
			chars_pending <= cipher_chars_due.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import kxb32_pkg::*;

	// Key register map; anything at or above KEY_WORDS is unmapped
	localparam logic [CFG_IDX_W-1:0] KEY_WORD_0   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD_1   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD_2   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD_3   = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 31;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 12;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic [7:0]           data_byte = 8'd0;
	logic                 last_byte = 1'b0;
	logic                 pop       = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = 64'd0;
	wire                  full;
	wire                  empty;
	wire  [6:0]           symbol_char;
	wire                  last_symbol;
	wire                  cfg_ready;

	int failures;
	int chars_pending;
	int cycle_count  = 0;
	bit steady       = 1'b0;  // both sides run without idling while set
	bit hold_request = 1'b0;  // asks the receiver for one long hold-off
	bit hold_done    = 1'b0;

	keyed_xor_base32_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.empty       (empty),
		.pop         (pop),
		.symbol_char (symbol_char),
		.last_symbol (last_symbol),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	b32_cipher_checker cipher_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.empty         (empty),
		.pop           (pop),
		.symbol_char   (symbol_char),
		.last_symbol   (last_symbol),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.chars_pending (chars_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog: drop the run if it never drains
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one byte and hold it until the transaction completes. Push stays
	// high on return so back-to-back bytes need no gap.
	task automatic send_byte(input logic [7:0] value, input logic frag_end);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= value;
		last_byte <= frag_end;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	// Random bytes, last flag on the final one
	task automatic send_fragment(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	// Stop offering and wait until the checker has nothing left due
	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Keep valid high between back-to-back writes; the caller lowers it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	// Write a decoy to an unmapped index first; it must leave the key alone
	task automatic load_keys(input logic [63:0] w0, input logic [63:0] w1,
		input logic [63:0] w2, input logic [63:0] w3,
		input logic [CFG_IDX_W-1:0] decoy_idx, input logic [63:0] decoy_value);
		cfg_write(decoy_idx, decoy_value);
		cfg_write(KEY_WORD_0, w0);
		cfg_write(KEY_WORD_1, w1);
		cfg_write(KEY_WORD_2, w2);
		cfg_write(KEY_WORD_3, w3);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Receiver: pop at random, once hold off for a long stretch so the block
	// fills up and pushes back on the sender
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	initial begin
		int budget;
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, zero key: the byte reaches the output only XORed with position
		load_keys(64'd0, 64'd0, 64'd0, 64'd0, CFG_UNMAPPED, '1);
		// single-byte fragments: one char plus a three-bit flush
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// five bytes make exactly eight chars: no flush, last mark on a regular char
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h0F, 1'b1);
		// two and three bytes: one-bit and four-bit flushes
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b1);
		drain();

		// Directed, all-ones key
		load_keys('1, '1, '1, '1, CFG_IDX_W'(KEY_WORDS), '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0F, 1'b1);
		drain();

		// Random phases, each with a fresh key. Phase 1 runs one fragment past
		// 256 bytes so the position wraps, with the receiver holding off; phase 2
		// runs with no idling on either side.
		for (int phase = 0; phase < 5; phase++) begin
			load_keys(random_word(), random_word(), random_word(), random_word(),
				CFG_IDX_W'($urandom_range(KEY_WORDS, 255)), random_word());
			steady <= (phase == 2);
			if (phase == 1) begin
				hold_request <= 1'b1;
				send_fragment($urandom_range(257, 262));
			end else begin
				budget = (phase == 2) ? 16 : 4;
				while (budget > 0) begin
					// mostly short fragments; long draws are cut to the budget, so none wraps the key
					len = ($urandom_range(0, 99) < 15) ? $urandom_range(33, 40)
						: $urandom_range(1, 12);
					if (len > budget) begin
						len = budget;
					end
					send_fragment(len);
					budget -= len;
				end
			end
			drain();
		end
		steady <= 1'b0;

		// Let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
